// ===== rtl/ipcmbx_pkg.sv =====
// Shared types, field widths, codes and helpers for the IPC endpoint mailbox table.
package ipcmbx_pkg;

    localparam int EP_COUNT_DEF     = 8;
    localparam int Q_SLOTS_DEF      = 4;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int CMD_W     = 2;
    localparam int TASK_W    = 16;
    localparam int NUM_W     = 8;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 3;
    localparam int CREATED_W = 4;
    localparam int WAKE_W    = 2;

    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RECV   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DENIED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd5;

    localparam logic [WAKE_W-1:0] WAKE_NONE     = 2'd0;
    localparam logic [WAKE_W-1:0] WAKE_RECEIVER = 2'd1;
    localparam logic [WAKE_W-1:0] WAKE_SENDER   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [TASK_W-1:0]    task_id;
        logic                 cap_granted;
        logic [NUM_W-1:0]     endpoint_number;
        logic [PAYLOAD_W-1:0] payload_in;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [CREATED_W-1:0] created_number;
        logic [PAYLOAD_W-1:0] payload_out;
        logic [TASK_W-1:0]    sender_out;
        logic [WAKE_W-1:0]    wake_request;
    } t_out_word;

    // Verdict of one command, held in the result register
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [CREATED_W-1:0] created_number;
        logic [WAKE_W-1:0]    wake_request;
    } t_verdict;

    // Queue store strobes for one command
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // Index width for a count of n, at least one bit
    function automatic int f_idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== rtl/ipcmbx_store.sv =====
// Message slot memory: payload and sender per slot, one write and one registered read.
module ipcmbx_store
    import ipcmbx_pkg::*;
#(
    parameter int DEPTH      = EP_COUNT_DEF * Q_SLOTS_DEF,
    parameter int ADDR_BITS  = f_idx_bits(EP_COUNT_DEF * Q_SLOTS_DEF),
    parameter int STORE_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                  i_clk,
    input  t_mem_ctl              i_ctl,
    input  logic [ADDR_BITS-1:0]  i_wr_addr,
    input  logic [ADDR_BITS-1:0]  i_rd_addr,
    input  logic [STORE_BITS-1:0] i_wr_payload,
    input  logic [TASK_W-1:0]     i_wr_sender,
    output logic [STORE_BITS-1:0] o_rd_payload,
    output logic [TASK_W-1:0]     o_rd_sender
);

    logic [STORE_BITS-1:0] r_payload_mem [DEPTH];
    logic [TASK_W-1:0]     r_sender_mem  [DEPTH];
    logic [STORE_BITS-1:0] r_rd_payload;
    logic [TASK_W-1:0]     r_rd_sender;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_payload_mem[i_wr_addr] <= i_wr_payload;
            r_sender_mem[i_wr_addr]  <= i_wr_sender;
        end
    end

    // Hold read data until the next receive so a stalled result stays put
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_payload <= r_payload_mem[i_rd_addr];
            r_rd_sender  <= r_sender_mem[i_rd_addr];
        end
    end

    assign o_rd_payload = r_rd_payload;
    assign o_rd_sender  = r_rd_sender;

endmodule

// ===== rtl/ipcmbx_ctrl.sv =====
// Endpoint table: active bits, ring pointers, fill counts and the per-command decision.
module ipcmbx_ctrl
    import ipcmbx_pkg::*;
#(
    parameter int ENDPOINT_COUNT = EP_COUNT_DEF,
    parameter int QUEUE_SLOTS    = Q_SLOTS_DEF,
    parameter int ADDR_BITS      = f_idx_bits(EP_COUNT_DEF * Q_SLOTS_DEF)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  t_in_word             i_word,
    output t_verdict             o_verdict,
    output t_mem_ctl             o_mem_ctl,
    output logic [ADDR_BITS-1:0] o_wr_addr,
    output logic [ADDR_BITS-1:0] o_rd_addr
);

    localparam int EW = f_idx_bits(ENDPOINT_COUNT);
    localparam int PW = f_idx_bits(QUEUE_SLOTS);
    localparam int CW = $clog2(QUEUE_SLOTS + 1);

    logic [ENDPOINT_COUNT-1:0] r_active;
    logic [PW-1:0]             r_rp  [ENDPOINT_COUNT];
    logic [PW-1:0]             r_wp  [ENDPOINT_COUNT];
    logic [CW-1:0]             r_cnt [ENDPOINT_COUNT];

    logic          w_free_found;
    logic [EW-1:0] w_free_idx;
    logic [NUM_W-1:0] w_num_m1;
    logic [EW-1:0] w_e;
    logic          w_num_ok;
    logic          w_ep_ok;
    logic [PW-1:0] w_rp;
    logic [PW-1:0] w_wp;
    logic [CW-1:0] w_cnt;
    logic [PW:0]   w_rp_inc;
    logic [PW:0]   w_wp_inc;
    logic [PW-1:0] w_rp_next;
    logic [PW-1:0] w_wp_next;
    logic          w_create_go;
    logic          w_send_go;
    logic          w_recv_go;

    // Lowest free endpoint
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = ENDPOINT_COUNT - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = EW'(i);
            end
        end
    end

    assign w_num_m1 = i_word.endpoint_number - NUM_W'(1);
    assign w_e      = w_num_m1[EW-1:0];
    assign w_num_ok = (i_word.endpoint_number != '0)
                   && ({1'b0, i_word.endpoint_number} <= (NUM_W + 1)'(ENDPOINT_COUNT));
    assign w_ep_ok  = w_num_ok && r_active[w_e];

    assign w_rp  = r_rp[w_e];
    assign w_wp  = r_wp[w_e];
    assign w_cnt = r_cnt[w_e];

    assign w_rp_inc  = {1'b0, w_rp} + (PW + 1)'(1);
    assign w_wp_inc  = {1'b0, w_wp} + (PW + 1)'(1);
    assign w_rp_next = (w_rp_inc >= (PW + 1)'(QUEUE_SLOTS)) ? '0 : w_rp_inc[PW-1:0];
    assign w_wp_next = (w_wp_inc >= (PW + 1)'(QUEUE_SLOTS)) ? '0 : w_wp_inc[PW-1:0];

    always_comb begin
        o_verdict.status         = ST_OK;
        o_verdict.created_number = '0;
        o_verdict.wake_request   = WAKE_NONE;
        w_create_go = 1'b0;
        w_send_go   = 1'b0;
        w_recv_go   = 1'b0;
        case (i_word.cmd)
            CMD_CREATE: begin
                if (w_free_found) begin
                    w_create_go = 1'b1;
                    o_verdict.created_number = CREATED_W'(int'(w_free_idx) + 1);
                end else begin
                    o_verdict.status = ST_TABLE_FULL;
                end
            end
            CMD_SEND, CMD_RECV: begin
                if (!i_word.cap_granted) begin
                    o_verdict.status = ST_DENIED;
                end else if (!w_ep_ok) begin
                    o_verdict.status = ST_INVALID;
                end else if (i_word.cmd == CMD_SEND) begin
                    if (w_cnt >= CW'(QUEUE_SLOTS)) begin
                        o_verdict.status = ST_FULL;
                    end else begin
                        w_send_go = 1'b1;
                        o_verdict.wake_request = WAKE_RECEIVER;
                    end
                end else begin
                    if (w_cnt == '0) begin
                        o_verdict.status = ST_EMPTY;
                    end else begin
                        w_recv_go = 1'b1;
                        o_verdict.wake_request = WAKE_SENDER;
                    end
                end
            end
            default: begin
                o_verdict.status = ST_INVALID;
            end
        endcase
    end

    assign o_mem_ctl.wr_en = i_fire && w_send_go;
    assign o_mem_ctl.rd_en = i_fire && w_recv_go;
    assign o_wr_addr = ADDR_BITS'(int'(w_e) * QUEUE_SLOTS + int'(w_wp));
    assign o_rd_addr = ADDR_BITS'(int'(w_e) * QUEUE_SLOTS + int'(w_rp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            for (int i = 0; i < ENDPOINT_COUNT; i++) begin
                r_rp[i]  <= '0;
                r_wp[i]  <= '0;
                r_cnt[i] <= '0;
            end
        end else if (i_fire) begin
            if (w_create_go) begin
                r_active[w_free_idx] <= 1'b1;
                r_rp[w_free_idx]     <= '0;
                r_wp[w_free_idx]     <= '0;
                r_cnt[w_free_idx]    <= '0;
            end
            if (w_send_go) begin
                r_wp[w_e]  <= w_wp_next;
                r_cnt[w_e] <= w_cnt + CW'(1);
            end
            if (w_recv_go) begin
                r_rp[w_e]  <= w_rp_next;
                r_cnt[w_e] <= w_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/ipc_endpoint_mailbox_table.sv =====
// Top level of the IPC endpoint mailbox table: input register, endpoint table, slot store, result.
//
//  channel   direction  handshake                     word
//  -------   ---------  ----------------------------  ----------
//  command   in         i_in_valid / o_in_stall       i_in_data
//  result    out        o_out_valid / i_out_stall     o_out_data
//
//  One word per cycle in steady state while the result side does not stall; a command
//  lands in the input register when taken, and its verdict is registered as it leaves.
//  The endpoint table is read and updated in the cycle the command leaves the
//  input register, so back-to-back commands on one endpoint see each other.
//  Reset (i_rst_n low at an edge) empties both registers and frees every
//  endpoint; slot contents are not cleared.
//  A stall on the result side holds a full result register and, once the input
//  register is full as well, raises o_in_stall in the same cycle.
module ipc_endpoint_mailbox_table
    import ipcmbx_pkg::*;
#(
    parameter int ENDPOINT_COUNT = EP_COUNT_DEF,
    parameter int QUEUE_SLOTS    = Q_SLOTS_DEF,
    parameter int PAYLOAD_BITS   = PAYLOAD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    localparam int SLOT_COUNT = ENDPOINT_COUNT * QUEUE_SLOTS;
    localparam int ADDR_BITS  = f_idx_bits(SLOT_COUNT);
    // Payload bits actually kept per slot
    localparam int STORE_BITS = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;

    logic     r_in_valid;
    t_in_word r_in;
    logic     r_out_valid;
    t_verdict r_res;

    logic                  w_adv;
    logic                  w_fire;
    t_verdict              w_verdict;
    t_mem_ctl              w_mem_ctl;
    logic [ADDR_BITS-1:0]  w_wr_addr;
    logic [ADDR_BITS-1:0]  w_rd_addr;
    logic [STORE_BITS-1:0] w_rd_payload;
    logic [TASK_W-1:0]     w_rd_sender;
    logic                  w_took;

    // Advance the result register when it is empty or being drained
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Load a new command word whenever the input register frees up
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    ipcmbx_ctrl #(
        .ENDPOINT_COUNT (ENDPOINT_COUNT),
        .QUEUE_SLOTS    (QUEUE_SLOTS),
        .ADDR_BITS      (ADDR_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_word    (r_in),
        .o_verdict (w_verdict),
        .o_mem_ctl (w_mem_ctl),
        .o_wr_addr (w_wr_addr),
        .o_rd_addr (w_rd_addr)
    );

    // Slot read data is registered inside the store, alongside r_res
    ipcmbx_store #(
        .DEPTH      (SLOT_COUNT),
        .ADDR_BITS  (ADDR_BITS),
        .STORE_BITS (STORE_BITS)
    ) u_store (
        .i_clk        (i_clk),
        .i_ctl        (w_mem_ctl),
        .i_wr_addr    (w_wr_addr),
        .i_rd_addr    (w_rd_addr),
        .i_wr_payload (r_in.payload_in[STORE_BITS-1:0]),
        .i_wr_sender  (r_in.task_id),
        .o_rd_payload (w_rd_payload),
        .o_rd_sender  (w_rd_sender)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_verdict;
        end
    end

    // Only a successful receive wakes a sender, so that code also marks valid read data
    assign w_took = (r_res.wake_request == WAKE_SENDER);

    assign o_out_valid               = r_out_valid;
    assign o_out_data.status         = r_res.status;
    assign o_out_data.created_number = r_res.created_number;
    assign o_out_data.wake_request   = r_res.wake_request;
    assign o_out_data.payload_out    = w_took ? PAYLOAD_W'(w_rd_payload) : '0;
    assign o_out_data.sender_out     = w_took ? w_rd_sender : '0;

    // A wake request only follows a successful send or receive
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.wake_request != WAKE_NONE)
            |-> (o_out_data.status == ST_OK))
        else $error("wake request on a failed command");

    // A created number is only given on a successful create
    a_created_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.created_number != '0)
            |-> (o_out_data.status == ST_OK) && (o_out_data.wake_request == WAKE_NONE))
        else $error("created number on a non-create result");

    // Table full never carries an endpoint number
    a_table_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_TABLE_FULL)
            |-> (o_out_data.created_number == '0))
        else $error("table full with an endpoint number");

    // A command that fires is held in the result register next cycle
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid && (r_res == $past(w_verdict)))
        else $error("fired command did not reach the result register");

    // No store write and read for one command, and a store write only when a command fires
    a_mem_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_mem_ctl.wr_en, w_mem_ctl.rd_en}) && (!w_mem_ctl.wr_en || w_fire))
        else $error("store strobes conflict");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the IPC endpoint mailbox table: directed and random commands.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipcmbx_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int STALL_LIMIT   = 5000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES  = 8;     // two register stages plus margin
    localparam int SLOT_W        = $clog2(Q_SLOTS_DEF);
    localparam int FILL_W        = $clog2(Q_SLOTS_DEF + 1);
    localparam int SEGMENTS      = 13;
    localparam int BLOCKS        = 5;
    localparam int BLOCK_WORDS   = 30;

    // The command field has one code with no operation behind it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {
        PACE_FREE,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    // Mirror of the endpoint table; predicts one result per command word
    class mailbox_mirror;
        bit                  ep_active   [EP_COUNT_DEF];
        bit [TASK_W-1:0]     ep_owner    [EP_COUNT_DEF];
        bit [SLOT_W-1:0]     rd_ptr      [EP_COUNT_DEF];
        bit [SLOT_W-1:0]     wr_ptr      [EP_COUNT_DEF];
        bit [FILL_W-1:0]     fill        [EP_COUNT_DEF];
        bit [PAYLOAD_W-1:0]  slot_payload[EP_COUNT_DEF*Q_SLOTS_DEF];
        bit [TASK_W-1:0]     slot_sender [EP_COUNT_DEF*Q_SLOTS_DEF];
        t_out_word           due_results [$];
        int                  bad_results;

        function int pending();
            return due_results.size();
        endfunction

        function void note_command(t_in_word w);
            t_out_word r;
            int        e;
            int        s;
            r = '0;
            r.status = ST_OK;
            case (w.cmd)
                CMD_CREATE: begin
                    r.status = ST_TABLE_FULL;
                    for (e = 0; e < EP_COUNT_DEF; e++) begin
                        if (!ep_active[e] && r.status == ST_TABLE_FULL) begin
                            ep_active[e] = 1'b1;
                            ep_owner[e]  = w.task_id;
                            rd_ptr[e]    = '0;
                            wr_ptr[e]    = '0;
                            fill[e]      = '0;
                            r.status         = ST_OK;
                            r.created_number = CREATED_W'(e + 1);
                        end
                    end
                end
                CMD_SEND, CMD_RECV: begin
                    // Capability verdict wins over a bad endpoint number
                    if (!w.cap_granted) begin
                        r.status = ST_DENIED;
                    end else if (w.endpoint_number == 0 || w.endpoint_number > EP_COUNT_DEF ||
                                 !ep_active[w.endpoint_number - 1]) begin
                        r.status = ST_INVALID;
                    end else begin
                        e = w.endpoint_number - 1;
                        if (w.cmd == CMD_SEND) begin
                            if (fill[e] == Q_SLOTS_DEF) begin
                                r.status = ST_FULL;
                            end else begin
                                s = e * Q_SLOTS_DEF + wr_ptr[e];
                                slot_payload[s] = w.payload_in;
                                slot_sender[s]  = w.task_id;
                                wr_ptr[e] = (wr_ptr[e] == Q_SLOTS_DEF - 1) ? '0 : wr_ptr[e] + 1'b1;
                                fill[e]   = fill[e] + 1'b1;
                                r.wake_request = WAKE_RECEIVER;
                            end
                        end else begin
                            if (fill[e] == 0) begin
                                r.status = ST_EMPTY;
                            end else begin
                                s = e * Q_SLOTS_DEF + rd_ptr[e];
                                r.payload_out = slot_payload[s];
                                r.sender_out  = slot_sender[s];
                                rd_ptr[e] = (rd_ptr[e] == Q_SLOTS_DEF - 1) ? '0 : rd_ptr[e] + 1'b1;
                                fill[e]   = fill[e] - 1'b1;
                                r.wake_request = WAKE_SENDER;
                            end
                        end
                    end
                end
                default: begin
                    r.status = ST_INVALID;
                end
            endcase
            due_results.push_back(r);
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp;
            if (due_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t: result word with nothing outstanding: %h", $realtime, got);
                return;
            end
            exp = due_results.pop_front();
            if (got.status !== exp.status || got.created_number !== exp.created_number ||
                got.payload_out !== exp.payload_out || got.sender_out !== exp.sender_out ||
                got.wake_request !== exp.wake_request) begin
                bad_results++;
                if (bad_results <= 10)
                    $display({"%0t: wrong result (expected/actual) status %0d/%0d ",
                              "created %0d/%0d payload %h/%h sender %h/%h wake %0d/%0d"},
                             $realtime, exp.status, got.status,
                             exp.created_number, got.created_number,
                             exp.payload_out, got.payload_out,
                             exp.sender_out, got.sender_out,
                             exp.wake_request, got.wake_request);
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_stall = 1'b0;
    t_in_word  i_in_data   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_data;

    mailbox_mirror mirror;
    int            sender_idle_pct = 0;
    int            receiver_stall_pct = 0;
    int            quiet_cycles = 0;

    ipc_endpoint_mailbox_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Receiver side: stall at random, decided at the falling edge
    always @(negedge i_clk) begin
        i_out_stall = i_rst_n && ($urandom_range(99) < receiver_stall_pct);
    end

    // Observe both handshakes at the rising edge; feed the mirror in
    // acceptance order and run the no-progress watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                mirror.note_command(i_in_data);
            if (o_out_valid && !i_out_stall)
                mirror.check_result(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_FREE:           begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            PACE_SENDER_IDLE:    begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
            PACE_RECEIVER_STALL: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
            default:             begin sender_idle_pct = 31; receiver_stall_pct = 31; end
        endcase
    endtask

    // Present one command word from a falling edge; hold it until taken,
    // then return at the next falling edge
    task automatic push_word(input t_in_word w);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = w;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [TASK_W-1:0] tid,
                         input logic granted, input logic [NUM_W-1:0] ep,
                         input logic [PAYLOAD_W-1:0] payload);
        t_in_word w;
        w.cmd             = cmd;
        w.task_id         = tid;
        w.cap_granted     = granted;
        w.endpoint_number = ep;
        w.payload_in      = payload;
        push_word(w);
    endtask

    // Mostly granted sends and receives on live endpoints; the rest is noise:
    // denied rights, stray endpoint numbers, creates on a full table, unused code
    function automatic t_in_word random_word(input int send_pct, input int focus_ep);
        t_in_word w;
        w.task_id     = TASK_W'($urandom);
        w.payload_in  = $urandom;
        w.cap_granted = 1'b1;
        if (focus_ep != 0 && $urandom_range(1) == 1)
            w.endpoint_number = NUM_W'(focus_ep);
        else
            w.endpoint_number = NUM_W'($urandom_range(1, EP_COUNT_DEF));
        w.cmd = ($urandom_range(99) < send_pct) ? CMD_SEND : CMD_RECV;
        if ($urandom_range(99) < 20) begin
            case ($urandom_range(4))
                0: w.cap_granted = 1'b0;
                1: w.endpoint_number = NUM_W'($urandom);
                2: w.endpoint_number = $urandom_range(1) ? '0 :
                                       NUM_W'($urandom_range(EP_COUNT_DEF + 1, 255));
                3: w.cmd = CMD_UNUSED;
                default: w.cmd = CMD_CREATE;
            endcase
        end
        return w;
    endfunction

    task automatic run_directed();
        int i;
        // Receive before anything exists: endpoint inactive
        issue(CMD_RECV, 16'h0000, 1'b1, 8'd1, 32'h0);
        // Fill the table; create ignores the right, the number and the payload
        for (i = 0; i < EP_COUNT_DEF; i++)
            issue(CMD_CREATE, i[0] ? 16'hFFFF : 16'h0000, i[1], NUM_W'($urandom), $urandom);
        issue(CMD_CREATE, 16'h5A5A, 1'b1, 8'd0, 32'hFFFF_FFFF);   // table full
        issue(CMD_SEND, 16'h1234, 1'b0, 8'd0, 32'h1);             // denied beats bad number
        issue(CMD_SEND, 16'h1234, 1'b1, 8'd0, 32'h1);             // number zero
        issue(CMD_SEND, 16'h1234, 1'b1, NUM_W'(EP_COUNT_DEF + 1), 32'h1);
        issue(CMD_SEND, 16'h1234, 1'b1, 8'hFF, 32'h1);
        // Fill endpoint 1 to the brim, then one more
        issue(CMD_SEND, 16'h0000, 1'b1, 8'd1, 32'h0000_0000);
        issue(CMD_SEND, 16'hFFFF, 1'b1, 8'd1, 32'hFFFF_FFFF);
        issue(CMD_SEND, 16'hA5A5, 1'b1, 8'd1, 32'hA5A5_A5A5);
        issue(CMD_SEND, 16'h5A5A, 1'b1, 8'd1, 32'h5A5A_5A5A);
        issue(CMD_SEND, 16'h7777, 1'b1, 8'd1, 32'h7777_7777);     // full
        // Drain it in order, then one more
        for (i = 0; i <= Q_SLOTS_DEF; i++)
            issue(CMD_RECV, 16'h0F0F, 1'b1, 8'd1, $urandom);
        issue(CMD_RECV, 16'hF0F0, 1'b0, 8'd2, 32'h0);             // denied receive
        issue(CMD_UNUSED, 16'hFFFF, 1'b1, 8'd1, 32'hFFFF_FFFF);
    endtask

    task automatic run_random();
        int seg;
        int blk;
        int send_pct;
        int focus_ep;
        for (seg = 0; seg < SEGMENTS; seg++) begin
            set_pace(pace_t'(seg % 4));
            for (blk = 0; blk < BLOCKS; blk++) begin
                // Lean toward sends or receives per block so queues hit full and empty
                case ($urandom_range(2))
                    0:       send_pct = 15;
                    1:       send_pct = 50;
                    default: send_pct = 85;
                endcase
                focus_ep = ($urandom_range(2) == 0) ? $urandom_range(1, EP_COUNT_DEF) : 0;
                repeat (BLOCK_WORDS) push_word(random_word(send_pct, focus_ep));
            end
        end
    endtask

    initial begin
        mirror = new();
        set_pace(PACE_FREE);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_random();
        i_in_valid = 1'b0;

        // Let every outstanding result drain, then give the pipe a few more cycles
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mirror.bad_results == 0 && mirror.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
